>>> design/lkma_pkg.sv
`timescale 1ns / 1ps
package lkma_pkg;

  localparam int TEMP_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int KEEP_W    = 8;
  localparam int OUT_CNT_W = 8;

  localparam logic signed [TEMP_W-1:0] LOW_LIMIT_RST  = -16'sd2560;
  localparam logic signed [TEMP_W-1:0] HIGH_LIMIT_RST = 16'sd32000;
  localparam logic [KEEP_W-1:0]        KEEP_COUNT_RST = 8'd77;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_LIMIT  = 2'd0,
    CFG_HIGH_LIMIT = 2'd1,
    CFG_KEEP_COUNT = 2'd2
  } cfg_idx_t;

  // one queued word from front to back
  typedef struct packed {
    logic                     keep;
    logic                     last;
    logic signed [TEMP_W-1:0] temp;
  } item_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] mean;
    logic                     none;
  } mean_t;

endpackage

>>> design/lkma_front.sv
`timescale 1ns / 1ps
module lkma_front (
  input  logic                                       in_tvalid,
  output logic                                       in_tready,
  input  logic signed [lkma_pkg::TEMP_W-1:0]         in_tdata,   // pixel_temp
  input  logic                                       in_tuser,   // pixel_invalid
  input  logic                                       in_tlast,
  input  logic signed [lkma_pkg::TEMP_W-1:0]         low_limit,
  input  logic signed [lkma_pkg::TEMP_W-1:0]         high_limit,
  input  logic                                       q_full,
  output logic                                       q_push,
  output lkma_pkg::item_t                            q_item
);

  logic keep;

  // words that are neither valid and within the limits nor end a frame are dropped here
  assign keep      = !in_tuser && (in_tdata >= low_limit) && (in_tdata <= high_limit);
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full && (keep || in_tlast);

  assign q_item.keep = keep;
  assign q_item.last = in_tlast;
  assign q_item.temp = in_tdata;

endmodule

>>> design/lkma_fifo.sv
`timescale 1ns / 1ps
module lkma_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lkma_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output lkma_pkg::item_t head_item
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  lkma_pkg::item_t  mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   fill_r, fill_nxt;

  assign full      = (fill_r == (PTR_W+1)'(DEPTH));
  assign valid     = (fill_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    fill_nxt   = fill_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> design/lkma_back.sv
`timescale 1ns / 1ps
module lkma_back #(
  parameter int KEEP_DEPTH = 128,
  parameter int CNT_W      = 8,
  parameter int SUM_W      = 23
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [lkma_pkg::KEEP_W-1:0]       keep_count,
  input  logic                              q_valid,
  input  lkma_pkg::item_t                   q_item,
  output logic                              q_pop,
  input  logic                              div_ready,
  output logic                              div_start,
  output logic signed [SUM_W-1:0]           div_sum,
  output logic [CNT_W-1:0]                  div_cnt
);

  localparam logic [8:0] DEPTH_9 = 9'(KEEP_DEPTH);

  logic signed [lkma_pkg::TEMP_W-1:0] cell_r [KEEP_DEPTH];
  logic [CNT_W-1:0]                   count_r, count_nxt;
  logic signed [SUM_W-1:0]            sum_r, sum_nxt;

  logic [KEEP_DEPTH-1:0]              in_use, gt, top_oh, wr_en;
  logic [8:0]                         cap_9;
  logic [CNT_W-1:0]                   cap;
  logic                               full, append, replace, ins;
  logic signed [lkma_pkg::TEMP_W-1:0] v, evicted;

  assign v = q_item.temp;

  always_comb begin
    if (keep_count == '0) begin
      cap_9 = 9'd1;
    end else if ({1'b0, keep_count} > DEPTH_9) begin
      cap_9 = DEPTH_9;
    end else begin
      cap_9 = {1'b0, keep_count};
    end
  end
  assign cap = cap_9[CNT_W-1:0];

  // cell chain: every cell compares against the new value in parallel
  for (genvar g = 0; g < KEEP_DEPTH; g++) begin : g_cell
    assign in_use[g] = (CNT_W'(g) < count_r);
    assign gt[g]     = in_use[g] && (cell_r[g] > v);
    assign top_oh[g] = in_use[g] && (CNT_W'(g + 1) == count_r);
    assign wr_en[g]  = ins && (gt[g] || (append && (CNT_W'(g) == count_r)));
    if (g == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (wr_en[g]) begin
          cell_r[g] <= v;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk) begin
        if (wr_en[g]) begin
          cell_r[g] <= gt[g-1] ? cell_r[g-1] : v;
        end
      end
    end
  end

  always_comb begin
    evicted = '0;
    for (int i = 0; i < KEEP_DEPTH; i++) begin
      evicted = evicted | (top_oh[i] ? cell_r[i] : '0);
    end
  end

  assign q_pop     = q_valid && (!q_item.last || div_ready);
  assign full      = (count_r >= cap);
  assign append    = q_pop && q_item.keep && !full;
  // sorted chain: any larger entry means the top entry is larger
  assign replace   = q_pop && q_item.keep && full && (|gt);
  assign ins       = append || replace;

  always_comb begin
    count_nxt = count_r + CNT_W'(append);
    sum_nxt   = sum_r + (ins ? SUM_W'(v) : '0) - (replace ? SUM_W'(evicted) : '0);
  end

  assign div_start = q_pop && q_item.last;
  assign div_sum   = sum_nxt;
  assign div_cnt   = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else if (q_pop) begin
      if (q_item.last) begin
        count_r <= '0;
        sum_r   <= '0;
      end else begin
        count_r <= count_nxt;
        sum_r   <= sum_nxt;
      end
    end
  end

endmodule

>>> design/lkma_div.sv
`timescale 1ns / 1ps
module lkma_div #(
  parameter int CNT_W = 8,
  parameter int SUM_W = 23
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] sum,
  input  logic [CNT_W-1:0]        cnt,
  output logic                    ready,
  output logic                    res_valid,
  input  logic                    res_ready,
  output lkma_pkg::mean_t         res,
  output logic [CNT_W-1:0]        res_cnt
);

  localparam int IT_W = $clog2(SUM_W);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } div_st_t;

  div_st_t                            st_r;
  logic [SUM_W-1:0]                   dvd_r;
  logic [CNT_W:0]                     rem_r;
  logic [CNT_W-1:0]                   den_r;
  logic                               neg_r;
  logic                               none_r;
  logic [IT_W-1:0]                    iter_r;
  logic signed [lkma_pkg::TEMP_W-1:0] mean_r;

  logic [SUM_W-1:0]                   mag, dvd_nxt;
  logic [CNT_W:0]                     rem_sh, rem_nxt;
  logic                               ge;
  logic [lkma_pkg::TEMP_W-1:0]        q_lo;

  // magnitude plus half the count gives round half away from zero
  always_comb begin
    mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    mag = mag + SUM_W'(cnt >> 1);
  end

  always_comb begin
    rem_sh  = {rem_r[CNT_W-1:0], dvd_r[SUM_W-1]};
    ge      = (rem_sh >= {1'b0, den_r});
    rem_nxt = ge ? rem_sh - {1'b0, den_r} : rem_sh;
    dvd_nxt = {dvd_r[SUM_W-2:0], ge};
    q_lo    = dvd_nxt[lkma_pkg::TEMP_W-1:0];
  end

  assign ready     = (st_r == ST_IDLE);
  assign res_valid = (st_r == ST_HOLD);
  assign res.mean  = mean_r;
  assign res.none  = none_r;
  assign res_cnt   = den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (start) begin
            den_r  <= cnt;
            neg_r  <= sum[SUM_W-1];
            dvd_r  <= mag;
            rem_r  <= '0;
            iter_r <= '0;
            none_r <= (cnt == '0);
            mean_r <= '0;
            st_r   <= (cnt == '0) ? ST_HOLD : ST_RUN;
          end
        end
        ST_RUN: begin
          dvd_r  <= dvd_nxt;
          rem_r  <= rem_nxt;
          iter_r <= iter_r + 1'b1;
          if (iter_r == IT_W'(SUM_W - 1)) begin
            mean_r <= neg_r ? -q_lo : q_lo;
            st_r   <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (res_ready) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> design/lowest_k_mean_ambient.sv
`timescale 1ns / 1ps
// Lowest-k mean of a thermal frame. Pixels (signed, 1/64 degree) enter one
// word per cycle while the queue is not full; invalid or out-of-limit pixels
// are dropped, the rest go through a four-word queue into a sorted chain of
// KEEP_DEPTH cells that inserts or replaces as each word is popped, so
// ordinary pixels sustain one per cycle. The last pixel of a frame hands the
// sum and count to a bit-serial divider, which loads them, forms the quotient
// bit by bit and passes the mean to the output register. Meanwhile the chain
// goes on with the next frame; only a further frame end waits at the queue
// head for the divider, and then the queue fills behind it. The mean word
// is held in an output register, so the next frame is taken while it waits.
module lowest_k_mean_ambient #(
  parameter int KEEP_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] pixel_temp
  input  logic        in_tuser,   // pixel_invalid
  input  logic        in_tlast,   // last_pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] ambient_mean, [23:16] kept_used
  output logic        out_tuser,  // none_kept
  input  logic        cfg_we,
  input  logic [lkma_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [lkma_pkg::CFG_W-1:0]     cfg_wdata
);

  localparam int CNT_W = $clog2(KEEP_DEPTH + 1);
  localparam int SUM_W = lkma_pkg::TEMP_W + $clog2(KEEP_DEPTH);

  logic signed [lkma_pkg::TEMP_W-1:0] low_r, high_r;
  logic [lkma_pkg::KEEP_W-1:0]        keep_r;

  logic                    q_push, q_full, q_pop, q_valid;
  lkma_pkg::item_t         q_in_item, q_head;
  logic                    div_ready, div_start;
  logic signed [SUM_W-1:0] div_sum;
  logic [CNT_W-1:0]        div_cnt;
  logic                    res_valid, res_ready;
  lkma_pkg::mean_t         res;
  logic [CNT_W-1:0]        res_cnt;

  logic                               out_valid_r;
  logic signed [lkma_pkg::TEMP_W-1:0] out_mean_r;
  logic [lkma_pkg::OUT_CNT_W-1:0]     out_cnt_r;
  logic                               out_none_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= lkma_pkg::LOW_LIMIT_RST;
      high_r <= lkma_pkg::HIGH_LIMIT_RST;
      keep_r <= lkma_pkg::KEEP_COUNT_RST;
    end else if (cfg_we) begin
      unique case (lkma_pkg::cfg_idx_t'(cfg_addr))
        lkma_pkg::CFG_LOW_LIMIT:  low_r  <= cfg_wdata;
        lkma_pkg::CFG_HIGH_LIMIT: high_r <= cfg_wdata;
        lkma_pkg::CFG_KEEP_COUNT: keep_r <= cfg_wdata[lkma_pkg::KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  lkma_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .low_limit  (low_r),
    .high_limit (high_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_in_item)
  );

  lkma_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head_item (q_head)
  );

  lkma_back #(
    .KEEP_DEPTH (KEEP_DEPTH),
    .CNT_W      (CNT_W),
    .SUM_W      (SUM_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .keep_count (keep_r),
    .q_valid    (q_valid),
    .q_item     (q_head),
    .q_pop      (q_pop),
    .div_ready  (div_ready),
    .div_start  (div_start),
    .div_sum    (div_sum),
    .div_cnt    (div_cnt)
  );

  lkma_div #(
    .CNT_W (CNT_W),
    .SUM_W (SUM_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .sum       (div_sum),
    .cnt       (div_cnt),
    .ready     (div_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .res_cnt   (res_cnt)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_mean_r <= res.mean;
      out_cnt_r  <= lkma_pkg::OUT_CNT_W'(res_cnt);
      out_none_r <= res.none;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_mean_r};
  assign out_tuser  = out_none_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> div_ready)
    else $error("frame end handed to busy divider");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |=> !div_ready)
    else $error("divider did not leave idle after start");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.none) |-> (res.mean == '0 && res_cnt == '0))
    else $error("empty frame gave nonzero mean or count");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int KEEP_DEPTH  = 128;
  localparam int SETTLE_CYC  = 40;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RAND_ITEMS  = 1200;

  typedef struct {
    logic signed [15:0] temp;
    logic               invalid;
    logic               last;
  } pixel_t;

  typedef struct {
    logic signed [15:0] mean;
    logic [7:0]         used;
    logic               none;
  } frame_mean_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;  // [15:0] pixel_temp
  logic        in_tuser = 1'b0;  // pixel_invalid
  logic        in_tlast = 1'b0;  // last_pixel
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;  // [15:0] ambient_mean, [23:16] kept_used
  logic        out_tuser;  // none_kept
  logic        cfg_we = 1'b0;
  logic [lkma_pkg::CFG_IDX_W-1:0] cfg_addr = lkma_pkg::CFG_LOW_LIMIT;
  logic [lkma_pkg::CFG_W-1:0]     cfg_wdata = '0;

  lowest_k_mean_ambient #(.KEEP_DEPTH(KEEP_DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state and its copy of the registers
  logic signed [15:0] lo_lim = lkma_pkg::LOW_LIMIT_RST;
  logic signed [15:0] hi_lim = lkma_pkg::HIGH_LIMIT_RST;
  logic [7:0]         keep_reg = lkma_pkg::KEEP_COUNT_RST;
  logic signed [15:0] kept_vals [KEEP_DEPTH];
  logic [7:0]         kept_n = '0;
  logic signed [22:0] kept_sum = '0;

  pixel_t      pixel_q[$];
  frame_mean_t mean_q[$];
  pixel_t      px;
  frame_mean_t want;

  bit quiet = 1'b0;
  bit in_taken = 1'b0;
  int px_gap = 0;
  int rdy_stall = 0;
  int px_queued = 0;
  int px_taken = 0;
  int frames_done = 0;
  int empty_frames = 0;
  int errs = 0;
  int cycles = 0;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(12, 50);
  endfunction

  function automatic void place_sorted(int pos, logic signed [15:0] v);
    int j;
    j = pos;
    while (j > 0 && kept_vals[j-1] > v) begin
      kept_vals[j] = kept_vals[j-1];
      j--;
    end
    kept_vals[j] = v;
  endfunction

  function automatic void fold_pixel(logic signed [15:0] temp, logic invalid, logic last);
    int cap;
    int top;
    int n;
    longint s;
    longint mag;
    longint q;
    frame_mean_t res;
    cap = (keep_reg == 0) ? 1 : (keep_reg > KEEP_DEPTH) ? KEEP_DEPTH : keep_reg;
    if (!invalid && temp >= lo_lim && temp <= hi_lim) begin
      if (kept_n < cap) begin
        place_sorted(kept_n, temp);
        kept_n++;
        kept_sum = kept_sum + temp;
      end else if (kept_n > 0) begin
        top = kept_n - 1;
        if (temp < kept_vals[top]) begin
          kept_sum = kept_sum - kept_vals[top];
          place_sorted(top, temp);
          kept_sum = kept_sum + temp;
        end
      end
    end
    if (last) begin
      n = kept_n;
      res.used = kept_n;
      res.none = (n == 0);
      res.mean = '0;
      if (n != 0) begin
        s = kept_sum;
        mag = (s < 0) ? -s : s;
        q = (mag + n / 2) / n;
        res.mean = 16'((s < 0) ? -q : q);
      end
      mean_q.push_back(res);
      kept_n = '0;
      kept_sum = '0;
    end
  endfunction

  // pixel driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (px_gap > 0) begin
        px_gap--;
        in_tvalid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        px = pixel_q.pop_front();
        in_tdata <= px.temp;
        in_tuser <= px.invalid;
        in_tlast <= px.last;
        in_tvalid <= 1'b1;
        px_gap = gap_len();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rdy_stall > 0) begin
      rdy_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      rdy_stall = gap_len();
    end
  end

  // monitor
  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (mean_q.size() == 0) begin
          $error("ambient word with no frame pending: %h / %b", out_tdata, out_tuser);
          errs++;
        end else begin
          want = mean_q.pop_front();
          frames_done++;
          if (want.none) empty_frames++;
          if (out_tdata[15:0] !== want.mean) begin
            $error("ambient_mean: expected %0d, got %0d", want.mean, $signed(out_tdata[15:0]));
            errs++;
          end
          if (out_tdata[23:16] !== want.used) begin
            $error("kept_used: expected %0d, got %0d", want.used, out_tdata[23:16]);
            errs++;
          end
          if (out_tuser !== want.none) begin
            $error("none_kept: expected %0b, got %0b", want.none, out_tuser);
            errs++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        px_taken++;
        fold_pixel(in_tdata, in_tuser, in_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_px(logic signed [15:0] temp, logic invalid, logic last);
    pixel_t p;
    p.temp = temp;
    p.invalid = invalid;
    p.last = last;
    pixel_q.push_back(p);
    px_queued++;
  endtask

  task automatic write_reg(lkma_pkg::cfg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      lkma_pkg::CFG_LOW_LIMIT:  lo_lim = val;
      lkma_pkg::CFG_HIGH_LIMIT: hi_lim = val;
      lkma_pkg::CFG_KEEP_COUNT: keep_reg = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (px_taken != px_queued || mean_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  function automatic logic signed [15:0] pick_temp();
    int lo;
    int hi;
    int r;
    int d;
    lo = lo_lim;
    hi = hi_lim;
    r = $urandom_range(0, 99);
    if (r < 25 || lo > hi) return 16'($urandom);
    if (r < 40) begin
      d = $urandom_range(0, 4);
      return 16'(($urandom_range(0, 1) ? lo : hi) + d - 2);
    end
    if (r < 60) begin
      d = $urandom_range(0, 7);
      return 16'(lo + d);
    end
    d = $urandom_range(0, hi - lo);
    return 16'(lo + d);
  endfunction

  initial begin
    int rnd_items;
    int r;
    int k;
    int nfr;
    int len;
    bit open_end;
    bit inv;
    logic [7:0] kv;
    logic signed [15:0] la;
    logic signed [15:0] lb;
    logic signed [15:0] lt;

    rnd_items = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // reset limits: empty frame, then both limits and their neighbors
    push_px(16'sd500, 1'b1, 1'b1);
    push_px(-16'sd32768, 1'b0, 1'b0);
    push_px(16'sd32767, 1'b0, 1'b0);
    push_px(-16'sd2561, 1'b0, 1'b0);
    push_px(16'sd32001, 1'b0, 1'b0);
    push_px(16'sd100, 1'b1, 1'b0);
    push_px(-16'sd2560, 1'b0, 1'b0);
    push_px(16'sd32000, 1'b0, 1'b1);
    settle();

    // keep count zero acts as one; equal values never evict
    write_reg(lkma_pkg::CFG_KEEP_COUNT, 16'd0);
    push_px(16'sd10, 1'b0, 1'b0);
    push_px(16'sd10, 1'b0, 1'b0);
    push_px(16'sd4, 1'b0, 1'b0);
    push_px(16'sd9, 1'b0, 1'b0);
    push_px(16'sd4, 1'b0, 1'b1);
    settle();

    // negative half rounds away from zero
    write_reg(lkma_pkg::CFG_KEEP_COUNT, 16'd2);
    push_px(-16'sd3, 1'b0, 1'b0);
    push_px(-16'sd4, 1'b0, 1'b1);
    settle();

    // crossed limits accept nothing
    write_reg(lkma_pkg::CFG_LOW_LIMIT, 16'sd100);
    write_reg(lkma_pkg::CFG_HIGH_LIMIT, 16'sd50);
    push_px(16'sd60, 1'b0, 1'b0);
    push_px(16'sd70, 1'b0, 1'b1);
    settle();

    // full range, keep count above depth saturates
    write_reg(lkma_pkg::CFG_LOW_LIMIT, -16'sd32768);
    write_reg(lkma_pkg::CFG_HIGH_LIMIT, 16'sd32767);
    write_reg(lkma_pkg::CFG_KEEP_COUNT, 16'd255);
    push_px(-16'sd32768, 1'b0, 1'b0);
    push_px(16'sd32767, 1'b0, 1'b1);
    settle();

    // keep count lowered in the middle of a frame
    write_reg(lkma_pkg::CFG_KEEP_COUNT, 16'd4);
    push_px(16'sd10, 1'b0, 1'b0);
    push_px(16'sd20, 1'b0, 1'b0);
    push_px(16'sd30, 1'b0, 1'b0);
    push_px(16'sd40, 1'b0, 1'b0);
    settle();
    write_reg(lkma_pkg::CFG_KEEP_COUNT, 16'd2);
    push_px(16'sd25, 1'b0, 1'b0);
    push_px(16'sd5, 1'b0, 1'b1);
    settle();

    while (rnd_items < RAND_ITEMS) begin
      r = $urandom_range(0, 9);
      case (r)
        0, 1: kv = 8'($urandom_range(1, 8));
        2, 3: kv = 8'($urandom_range(9, 40));
        4: kv = 8'(KEEP_DEPTH);
        5: kv = 8'd0;
        6: kv = 8'($urandom_range(129, 255));
        7: kv = 8'd1;
        default: kv = 8'($urandom_range(41, 127));
      endcase
      r = $urandom_range(0, 9);
      if (r < 5) begin
        la = lkma_pkg::LOW_LIMIT_RST;
        lb = lkma_pkg::HIGH_LIMIT_RST;
      end else if (r < 7) begin
        la = -16'sd32768;
        lb = 16'sd32767;
      end else begin
        la = 16'($urandom);
        lb = 16'($urandom);
        if (r < 9 && la > lb) begin
          lt = la;
          la = lb;
          lb = lt;
        end
      end
      write_reg(lkma_pkg::CFG_LOW_LIMIT, la);
      write_reg(lkma_pkg::CFG_HIGH_LIMIT, lb);
      write_reg(lkma_pkg::CFG_KEEP_COUNT, {8'd0, kv});
      k = (kv == 0) ? 1 : (kv > KEEP_DEPTH) ? KEEP_DEPTH : kv;
      quiet = ($urandom_range(0, 3) == 0);
      nfr = $urandom_range(1, 4);
      open_end = ($urandom_range(0, 9) == 0);
      for (int f = 0; f < nfr; f++) begin
        if ($urandom_range(0, 9) == 0) len = $urandom_range(k, (k + 60 > 200) ? 200 : k + 60);
        else len = $urandom_range(1, (k < 10) ? 2 * k + 4 : 24);
        for (int i = 0; i < len; i++) begin
          inv = ($urandom_range(0, 11) == 0);
          push_px(pick_temp(), inv, (i == len - 1) && !(f == nfr - 1 && open_end));
          if (!inv) rnd_items++;
        end
      end
      settle();
    end

    // close any frame left open by the last phase
    push_px(16'sd0, 1'b0, 1'b1);
    settle();

    $display("%0d pixels in %0d frame means checked, %0d of them with nothing kept",
             px_taken, frames_done, empty_frames);
    $display("keep count swept from 0 to 255 with default, full-range and crossed limits");
    if (errs == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
design/lkma_pkg.sv
design/lkma_front.sv
design/lkma_fifo.sv
design/lkma_back.sv
design/lkma_div.sv
design/lowest_k_mean_ambient.sv
tb/tb.sv
